[rtl/lte_pkg.sv]
package lte_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_FINDH = 2'd1;
	localparam logic [1:0] KIND_FINDA = 2'd2;
	localparam logic [1:0] KIND_CHECK = 2'd3;

	typedef struct packed {
		logic [63:0] hw_high;
		logic [63:0] hw_low;
		logic [31:0] address;
		logic [31:0] expiry;
	} entry_t;

	// command as classified by the front end
	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] hw_high;
		logic [63:0] hw_low;
		logic [31:0] address;
		logic [31:0] seconds;
		logic [7:0]  index;
		logic [31:0] now;
		logic        hw_nz;
		logic        ip_nz;
	} cmd_t;

	typedef struct packed {
		logic        found;
		logic [7:0]  slot;
		entry_t      entry;
		logic        was_expired;
	} res_t;

endpackage

[rtl/lte_front.sv]
module lte_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [63:0]       hw_addr_high,
	input  logic [63:0]       hw_addr_low,
	input  logic [31:0]       ip_address,
	input  logic [31:0]       lease_seconds,
	input  logic [7:0]        entry_index,
	input  logic [31:0]       now,
	output logic              cmd_valid,
	output lte_pkg::cmd_t     cmd,
	input  logic              cmd_pop
);

	lte_pkg::cmd_t fifo_q [lte_pkg::QUEUE_DEPTH];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	lte_pkg::cmd_t incoming;
	logic          push;
	logic          pop;

	always_comb begin
		incoming.kind    = kind;
		incoming.hw_high = hw_addr_high;
		incoming.hw_low  = hw_addr_low;
		incoming.address = ip_address;
		incoming.seconds = lease_seconds;
		incoming.index   = entry_index;
		incoming.now     = now;
		incoming.hw_nz   = (hw_addr_high != 64'd0) || (hw_addr_low != 64'd0);
		incoming.ip_nz   = ip_address != 32'd0;
	end

	assign in_ready  = count_q != 2'(lte_pkg::QUEUE_DEPTH);
	assign push      = in_valid && in_ready;
	assign cmd_valid = count_q != 2'd0;
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[rtl/lte_back.sv]
module lte_back #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]    limit,
	input  logic                                cmd_valid,
	input  lte_pkg::cmd_t                       cmd,
	output logic                                cmd_pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output lte_pkg::res_t                       res
);

	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLR   = 3'd1;
	localparam logic [2:0] ST_OLD   = 3'd2;
	localparam logic [2:0] ST_WR    = 3'd3;
	localparam logic [2:0] ST_FIND  = 3'd4;
	localparam logic [2:0] ST_CHKRD = 3'd5;
	localparam logic [2:0] ST_CHKEV = 3'd6;
	localparam logic [2:0] ST_RESP  = 3'd7;

	lte_pkg::entry_t        mem [TABLE_DEPTH];
	lte_pkg::entry_t        rd_q;
	logic [TABLE_DEPTH-1:0] valid_q;

	logic [2:0]    state_q;
	lte_pkg::cmd_t cmd_q;
	lte_pkg::res_t res_q;
	lte_pkg::res_t out_q;
	logic          out_valid_q;
	logic [CW-1:0] cnt_q;
	logic          pend_q;
	logic [IW-1:0] pidx_q;
	logic [31:0]   best_q;
	logic [IW-1:0] pick_q;
	logic          have_q;

	logic            scanning;
	logic            issue;
	logic [IW-1:0]   rd_addr;
	logic            scan_done;
	lte_pkg::entry_t cur;
	logic            hw_eq;
	logic            ip_eq;
	logic            clr_hit;
	logic            chk_exp;
	logic            chk_in_range;
	lte_pkg::entry_t new_entry;
	logic            out_free;

	assign scanning = (state_q == ST_CLR) || (state_q == ST_OLD) || (state_q == ST_FIND);
	assign issue    = scanning && (cnt_q < limit);
	assign rd_addr  = (state_q == ST_CHKRD) ? IW'(cmd_q.index) : cnt_q[IW-1:0];
	assign scan_done = !issue && !pend_q;
	assign cur      = valid_q[pidx_q] ? rd_q : '0;
	assign hw_eq    = (cur.hw_high == cmd_q.hw_high) && (cur.hw_low == cmd_q.hw_low);
	assign ip_eq    = cur.address == cmd_q.address;
	assign clr_hit  = pend_q && ((cmd_q.hw_nz && hw_eq) || (cmd_q.ip_nz && ip_eq));
	assign chk_exp  = (cur.expiry != 32'd0) && (cur.expiry < cmd_q.now);
	assign chk_in_range = 32'(cmd.index) < 32'(limit);
	assign out_free = !out_valid_q || out_ready;
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;

	always_comb begin
		new_entry.hw_high = cmd_q.hw_high;
		new_entry.hw_low  = cmd_q.hw_low;
		new_entry.address = cmd_q.address;
		new_entry.expiry  = cmd_q.now + cmd_q.seconds;
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (state_q == ST_WR) begin
			mem[pick_q] <= new_entry;
		end
	end

	// entry valid bits: an invalid entry reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (state_q == ST_CLR && clr_hit) begin
				valid_q[pidx_q] <= 1'b0;
			end
			if (state_q == ST_CHKEV && chk_exp) begin
				valid_q[pidx_q] <= 1'b0;
			end
			if (state_q == ST_WR) begin
				valid_q[pick_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		pidx_q <= (state_q == ST_CHKRD) ? IW'(cmd_q.index) : cnt_q[IW-1:0];
		case (state_q)
			ST_IDLE: begin
				res_q <= '0;
			end
			ST_OLD: begin
				if (pend_q && cur.expiry < best_q) begin
					best_q <= cur.expiry;
					pick_q <= pidx_q;
				end
			end
			ST_WR: begin
				res_q.found       <= 1'b1;
				res_q.slot        <= 8'(pick_q);
				res_q.entry       <= new_entry;
				res_q.was_expired <= 1'b0;
			end
			ST_FIND: begin
				if (pend_q && ((cmd_q.kind == lte_pkg::KIND_FINDH) ? hw_eq : ip_eq)) begin
					res_q.found <= 1'b1;
					res_q.slot  <= 8'(pidx_q);
					res_q.entry <= cur;
				end
			end
			ST_CHKEV: begin
				res_q.found       <= 1'b1;
				res_q.slot        <= 8'(pidx_q);
				res_q.entry       <= cur;
				res_q.was_expired <= chk_exp;
			end
			ST_CLR: begin
				best_q <= cmd_q.now;
			end
			default: begin
			end
		endcase
		if (state_q == ST_RESP && out_free) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (scanning) begin
				pend_q <= issue;
				if (issue) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end else begin
				pend_q <= 1'b0;
				cnt_q  <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					have_q <= 1'b0;
					if (cmd_valid) begin
						case (cmd.kind)
							lte_pkg::KIND_ADD:   state_q <= ST_CLR;
							lte_pkg::KIND_CHECK: state_q <= chk_in_range ? ST_CHKRD : ST_RESP;
							default:             state_q <= ST_FIND;
						endcase
					end
				end
				ST_CLR: begin
					if (scan_done) begin
						state_q <= ST_OLD;
						cnt_q   <= '0;
					end
				end
				ST_OLD: begin
					if (pend_q && cur.expiry < best_q) begin
						have_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= (have_q || (pend_q && cur.expiry < best_q)) ? ST_WR : ST_RESP;
					end
				end
				ST_WR: begin
					state_q <= ST_RESP;
				end
				ST_FIND: begin
					if ((pend_q && ((cmd_q.kind == lte_pkg::KIND_FINDH) ? hw_eq : ip_eq))
						|| scan_done) begin
						state_q <= ST_RESP;
					end
				end
				ST_CHKRD: begin
					state_q <= ST_CHKEV;
				end
				ST_CHKEV: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign res       = out_q;

endmodule

[rtl/lease_table_engine.sv]
// channel  | handshake              | payload
// in       | in_valid / in_ready    | kind, hw_addr_high/low, ip_address, lease_seconds,
//          |                        | entry_index, now
// out      | out_valid / out_ready  | found, slot, entry_hw_high/low, entry_address,
//          |                        | entry_expiry, was_expired
// cfg      | cfg_valid / cfg_ready  | cfg_data (active_entries, 9 bits)
//
// Flow: add scans the table to clear matches, then again to pick an expired entry, and
// writes only if one is chosen; finds scan up to N entries (N = active entry count);
// check reads one entry. Scans do one table read per cycle via the single read port.
// Reset: valid bits cleared at once, so the table reads as empty; active count resets to 256.
// Stalls: a two-deep command queue keeps taking transactions while the back end works,
// and the result register holds while out_ready is low.
module lease_table_engine #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [63:0] hw_addr_high,
	input  logic [63:0] hw_addr_low,
	input  logic [31:0] ip_address,
	input  logic [31:0] lease_seconds,
	input  logic [7:0]  entry_index,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [7:0]  slot,
	output logic [63:0] entry_hw_high,
	output logic [63:0] entry_hw_low,
	output logic [31:0] entry_address,
	output logic [31:0] entry_expiry,
	output logic        was_expired,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);

	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	logic [8:0]    active_q;
	logic [31:0]   lim_wide;
	logic [CW-1:0] limit;
	logic          cmd_valid;
	logic          cmd_pop;
	lte_pkg::cmd_t cmd;
	lte_pkg::res_t res;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 9'd256;
		end else if (cfg_valid) begin
			active_q <= cfg_data;
		end
	end

	// counts above the table size saturate
	assign lim_wide = (32'(active_q) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : 32'(active_q);
	assign limit    = CW'(lim_wide);

	lte_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.hw_addr_high  (hw_addr_high),
		.hw_addr_low   (hw_addr_low),
		.ip_address    (ip_address),
		.lease_seconds (lease_seconds),
		.entry_index   (entry_index),
		.now           (now),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop)
	);

	lte_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (limit),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign found         = res.found;
	assign slot          = res.slot;
	assign entry_hw_high = res.entry.hw_high;
	assign entry_hw_low  = res.entry.hw_low;
	assign entry_address = res.entry.address;
	assign entry_expiry  = res.entry.expiry;
	assign was_expired   = res.was_expired;

endmodule
